// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the descrambler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fxd_pkg.sv =====
// Types and constants of the feedback XOR block descrambler.
package fxd_pkg;

  localparam int unsigned KEY_COUNT       = 7;
  localparam int unsigned WORDS_PER_ROUND = 8;
  localparam int unsigned SLOT_W          = $clog2(WORDS_PER_ROUND);
  localparam int unsigned MIX_KEY_A       = 2;
  localparam int unsigned MIX_KEY_B       = 4;
  localparam logic [31:0] SHIFT_BASE      = 32'h0000_005a;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WORDS_PER_ROUND - 1);

  localparam logic [31:0] INIT_KEY_RESET [KEY_COUNT] = '{
    32'd173185410, 32'd3733782861, 32'd4277543931, 32'd634790577,
    32'd203830975, 32'd3447766296, 32'd1672219801
  };
  localparam logic [31:0] SEED_RESET = 32'd3011917571;

  typedef enum logic [2:0] {
    CFG_KEY1 = 3'd0,
    CFG_KEY2 = 3'd1,
    CFG_KEY3 = 3'd2,
    CFG_KEY4 = 3'd3,
    CFG_KEY5 = 3'd4,
    CFG_KEY6 = 3'd5,
    CFG_KEY7 = 3'd6,
    CFG_SEED = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [4:0]  key_shift;
  } in_t;

  typedef struct packed {
    logic [31:0] plain_word;
    logic        block_end;
  } out_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0][31:0] init_key;
    logic [31:0]                feedback_seed;
  } cfg_regs_t;

endpackage

// ===== rtl/core/fxd_cfg.sv =====
// Configuration register file: seven initial key words and the feedback seed.
module fxd_cfg
  import fxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  cfg_index_t wr_index,
  input  logic [31:0] wr_data,
  output cfg_regs_t  regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        regs.init_key[k] <= INIT_KEY_RESET[k];
      end
      regs.feedback_seed <= SEED_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SEED: begin
          regs.feedback_seed <= wr_data;
        end
        default: begin
          regs.init_key[wr_index] <= wr_data;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fxd_datapath.sv =====
// Key state, word position and the XOR datapath for one word per cycle while advance is high.
`include "assert_macros.svh"

module fxd_datapath
  import fxd_pkg::*;
#(
  parameter int unsigned ROUNDS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_t       item,
  input  cfg_regs_t regs,
  output out_t      result
);

  localparam int unsigned BLOCK_LEN = ROUNDS * WORDS_PER_ROUND;
  localparam int unsigned POS_W     = $clog2(BLOCK_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

  logic [POS_W-1:0]                 pos;
  logic [KEY_COUNT-1:0][31:0]       key_words;
  logic [KEY_COUNT-1:0][31:0]       cur_keys;
  logic [WORDS_PER_ROUND-1:0][31:0] word_keys;
  logic [31:0]                      shift_term;
  logic [SLOT_W-1:0]                slot;
  logic                             block_start;

  assign slot        = pos[SLOT_W-1:0];
  assign block_start = (pos == '0);
  assign shift_term  = SHIFT_BASE << item.key_shift;

  // On a block's first word the keys come from config, XORed with SHIFT_BASE shifted by key_shift.
  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      cur_keys[k]  = block_start ? (regs.init_key[k] ^ shift_term) : key_words[k];
      word_keys[k] = cur_keys[k];
    end
    word_keys[LAST_SLOT] = cur_keys[MIX_KEY_A] ^ cur_keys[MIX_KEY_B];
  end

  assign result.plain_word = item.data_word ^ word_keys[slot];
  assign result.block_end  = (pos == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
    end
  end

  // Round end: shift keys down, feed the last output XOR the feedback seed back in at the top.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (slot == LAST_SLOT) begin
        for (int k = 0; k < KEY_COUNT - 1; k++) begin
          key_words[k] <= cur_keys[k+1];
        end
        key_words[KEY_COUNT-1] <= result.plain_word ^ regs.feedback_seed;
      end else begin
        key_words <= cur_keys;
      end
    end
  end

  `ASSERT_NEXT(a_pos_wrap, clk, rst, advance && pos == LAST_POS, pos == '0,
               "position did not wrap at block end")
  `ASSERT_NEXT(a_pos_hold, clk, rst, !advance, $stable(pos),
               "position moved without a beat")
  `ASSERT_NEXT(a_feedback, clk, rst, advance && slot == LAST_SLOT,
               key_words[KEY_COUNT-1] == $past(result.plain_word ^ regs.feedback_seed),
               "feedback key word wrong after round end")
  `ASSERT_NEXT(a_block_load, clk, rst, advance && block_start,
               key_words[0] == $past(regs.init_key[0] ^ shift_term),
               "key word not loaded at block start")

endmodule

// ===== rtl/core/feedback_xor_block_descrambler_core.sv =====
// Top level of the feedback XOR block descrambler: input and output registers.
//
// Usage:
//  - in_valid/in_ready/in_data carry one scrambled 32-bit word per beat plus
//    key_shift, which is used only on the first word of each block.
//  - out_valid/out_ready/out_data carry one descrambled word per beat, with
//    block_end set on word ROUNDS*8-1 of every block.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write the seven initial key words
//    (index 0..6) and the feedback seed (index 7); cfg_ready is always high.
//    Write only while no word is in flight.
// Path: an input beat is captured in the input register, then in the output
// register, which drives out_valid; throughput is one word per cycle while out_ready
// keeps the output register free, set by the key update loop in the datapath.
// Reset (rst, synchronous) empties both registers, restores the config
// defaults and puts the word position at the start of a block.
// When out_ready is low a full output register holds its word, and the input
// register takes one more beat only if it is empty before in_ready drops.
module feedback_xor_block_descrambler_core
  import fxd_pkg::*;
#(
  parameter int unsigned ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [31:0] cfg_data
);

  logic      in_buf_valid;
  in_t       in_buf;
  logic      out_buf_valid;
  out_t      out_buf;
  out_t      result;
  cfg_regs_t regs;
  logic      advance;

  assign advance   = in_buf_valid && (!out_buf_valid || out_ready);
  assign in_ready  = !in_buf_valid || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_buf_valid;
  assign out_data  = out_buf;

  fxd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  fxd_datapath #(
    .ROUNDS (ROUNDS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_buf),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_buf_valid <= 1'b0;
    end else if (in_ready) begin
      in_buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buf <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_buf_valid <= 1'b0;
    end else if (advance) begin
      out_buf_valid <= 1'b1;
    end else if (out_ready) begin
      out_buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_buf <= result;
    end
  end

endmodule

// ===== bench/feedback_xor_block_descrambler_core_test.sv =====
// Self-checking bench for the feedback XOR block descrambler core.
`timescale 1ns / 1ps

module feedback_xor_block_descrambler_core_test;
  import fxd_pkg::*;

  localparam int unsigned ROUNDS       = 16;
  localparam int unsigned BLOCK_LEN    = ROUNDS * WORDS_PER_ROUND;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned SETTLE       = 6;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_KEY1;
  logic [31:0] cfg_data = '0;

  feedback_xor_block_descrambler_core #(
    .ROUNDS(ROUNDS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // descrambler state as the bench sees it
  logic [31:0] init_key_reg [KEY_COUNT];
  logic [31:0] seed_reg;
  logic [31:0] round_keys [KEY_COUNT];
  int unsigned word_pos;

  out_t plain_queue [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned blocks_seen = 0;
  int unsigned reg_writes = 0;
  logic [4:0]  start_shift = '0;
  bit          flip_start = 1'b0;

  task automatic reset_model();
    for (int i = 0; i < KEY_COUNT; i++) begin
      init_key_reg[i] = INIT_KEY_RESET[i];
      round_keys[i]   = '0;
    end
    seed_reg = SEED_RESET;
    word_pos = 0;
  endtask

  function automatic out_t descramble_word(input in_t beat);
    out_t        res;
    logic [31:0] term;
    int unsigned slot;
    if (word_pos == 0) begin
      term = SHIFT_BASE << beat.key_shift;
      for (int i = 0; i < KEY_COUNT; i++) round_keys[i] = init_key_reg[i] ^ term;
    end
    slot = word_pos % WORDS_PER_ROUND;
    if (slot < KEY_COUNT) begin
      res.plain_word = beat.data_word ^ round_keys[slot];
    end else begin
      res.plain_word = beat.data_word ^ round_keys[MIX_KEY_A] ^ round_keys[MIX_KEY_B];
      for (int i = 0; i + 1 < KEY_COUNT; i++) round_keys[i] = round_keys[i + 1];
      round_keys[KEY_COUNT - 1] = res.plain_word ^ seed_reg;
    end
    res.block_end = (word_pos == BLOCK_LEN - 1);
    word_pos = res.block_end ? 0 : word_pos + 1;
    return res;
  endfunction

  // receiver ready: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= STALL_CYCLES;
      out_ready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (plain_queue.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, out_data);
        error_count++;
      end else begin
        want = plain_queue.pop_front();
        if (out_data.plain_word !== want.plain_word) begin
          $display("%0t: plain_word expected %h got %h", $time, want.plain_word,
                   out_data.plain_word);
          error_count++;
        end
        if (out_data.block_end !== want.block_end) begin
          $display("%0t: block_end expected %b got %b", $time, want.block_end,
                   out_data.block_end);
          error_count++;
        end
      end
      words_checked++;
      if (out_data.block_end === 1'b1) blocks_seen++;
    end
  end

  // leaves in_valid high so back-to-back beats need no gap
  task automatic send_word(input in_t beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    plain_queue.push_back(descramble_word(beat));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (plain_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SEED) seed_reg = value;
    else init_key_reg[idx] = value;
    reg_writes++;
  endtask

  // only called with nothing in flight
  task automatic program_regs(input fill_t fill);
    logic [31:0] value;
    for (int i = 0; i <= CFG_SEED; i++) begin
      case (fill)
        FILL_ZERO: value = '0;
        FILL_ONES: value = '1;
        default:   value = $urandom;
      endcase
      write_reg(cfg_index_t'(i), value);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t random_beat();
    in_t beat;
    case ($urandom_range(15))
      0:       beat.data_word = '0;
      1:       beat.data_word = '1;
      default: beat.data_word = $urandom;
    endcase
    if (word_pos == 0) begin
      // alternate with the complement so every shift bit sees both values
      start_shift = flip_start ? ~start_shift : 5'($urandom_range(31));
      flip_start  = !flip_start;
      beat.key_shift = start_shift;
    end else begin
      beat.key_shift = 5'($urandom_range(31));
    end
    return beat;
  endfunction

  // extremes of data, shift all ones at block start, shift ignored afterwards
  task automatic test_directed_words();
    in_t beat;
    for (int i = 0; i < 24; i++) begin
      case (i % 4)
        0: beat.data_word = '0;
        1: beat.data_word = '1;
        2: beat.data_word = 32'haaaa_aaaa;
        default: beat.data_word = $urandom;
      endcase
      beat.key_shift = (i == 0) ? 5'h1f : 5'(i);
      send_word(beat);
    end
    wait_drained();
  endtask

  // keys change mid-block: seed takes effect at the next round end, keys next block
  task automatic test_config_mid_block();
    program_regs(FILL_RANDOM);
    for (int i = 0; i < 24; i++) send_word(random_beat());
    wait_drained();
  endtask

  task automatic test_random_phase(input fill_t fill, input int unsigned count,
                                   input int unsigned tx_pct, input int unsigned rx_pct);
    program_regs(fill);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int i = 0; i < count; i++) send_word(random_beat());
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_long_stall();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    stall_requests <= stall_requests + 1;
    for (int i = 0; i < 40; i++) send_word(random_beat());
    wait_drained();
    for (int i = 0; i < 20; i++) send_word(random_beat());
    wait_drained();
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_words();
    test_config_mid_block();
    test_random_phase(FILL_ZERO, 320, 10, 70);
    test_random_phase(FILL_ONES, 320, 70, 10);
    test_random_phase(FILL_RANDOM, 320, 0, 0);
    test_long_stall();
    test_random_phase(FILL_RANDOM, 60, 30, 30);
    repeat (20) @(posedge clk);
    $display("Sent %0d words, checked %0d, %0d blocks ended, %0d register writes;",
             words_sent, words_checked, blocks_seen, reg_writes);
    $display("zero, all-ones and random keys, mid-block writes, idle mixes and a long stall.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d beats still expected", plain_queue.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
